// ===== design/flow_meter_pulse_rate_unit_macros.svh =====
// Assertion helpers shared by the flow meter RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef FLOW_METER_PULSE_RATE_UNIT_MACROS_SVH
`define FLOW_METER_PULSE_RATE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// ante true -> cons true in the same cycle
`define FMPR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante true -> cons true in the next cycle
`define FMPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// expr never true
`define FMPR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define FMPR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define FMPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define FMPR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/frp_pkg.sv =====
`default_nettype none

package frp_pkg;

    // field widths
    localparam int unsigned CAP_W      = 10;
    localparam int unsigned K_W        = 16;
    localparam int unsigned M_W        = 16;
    localparam int unsigned DUR_W      = 32;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned DEC_W      = 4;
    localparam int unsigned SUM_W      = 48;
    localparam int unsigned SUMC_W     = 64;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned MHIGH_W    = 32;

    // internal widths
    localparam int unsigned CK_W = CAP_W + K_W;     // capacity * k
    localparam int unsigned CD_W = K_W + DUR_W;     // correction * duration

    // shared divider
    localparam int unsigned DIV_NUM_W = 64;
    localparam int unsigned DIV_DEN_W = CK_W + 8;   // widest divisor: 256*capacity*k
    localparam int unsigned DIV_Q_W   = 32;
    localparam int unsigned DIV_CNT_W = 6;

    // quotient lengths per division
    localparam logic [DIV_CNT_W-1:0] STEPS_VAL  = DIV_CNT_W'(VAL_W);
    localparam logic [DIV_CNT_W-1:0] STEPS_CORR = DIV_CNT_W'(K_W);
    localparam logic [DIV_CNT_W-1:0] STEPS_DEC  = DIV_CNT_W'(DEC_W);

    localparam int unsigned PULSE_COUNT_WIDTH_DEF = 16;

    // arithmetic constants
    localparam logic [DIV_NUM_W-1:0] FREQ_SCALE   = 64'd65536000; // 1000 ms/s in Q16.16
    localparam logic [DIV_NUM_W-1:0] DECILE_SCALE = 64'd10;
    localparam logic [DIV_DEN_W-1:0] MS_PER_MIN   = 34'd60000;
    localparam logic [DEC_W-1:0]     DEC_MAX      = 4'd9;

    // register reset values
    localparam logic [CAP_W-1:0]      CAPACITY_RST = 10'd60;
    localparam logic [K_W-1:0]        K_FACTOR_RST = 16'd1280;
    localparam logic [CFG_DATA_W-1:0] M_LOW_RST    = 64'h4000_4000_4000_4000;
    localparam logic [CFG_DATA_W-1:0] M_MID_RST    = 64'h4000_4000_4000_4000;
    localparam logic [MHIGH_W-1:0]    M_HIGH_RST   = 32'h4000_4000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_M_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M_MID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_M_HIGH   = 3'd4;

    // input word kinds
    localparam logic [KIND_W-1:0] KIND_PULSE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic                 go;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== design/frp_div.sv =====
`default_nettype none
`include "flow_meter_pulse_rate_unit_macros.svh"

// Restoring divider, one quotient bit per cycle, saturating.
// quot = min(num / den, 2^steps - 1); a zero divisor saturates.
module frp_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire frp_pkg::t_div_req              i_req,
    input  wire logic [frp_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [frp_pkg::DIV_DEN_W-1:0]  i_den,
    output frp_pkg::t_div_stat                  o_stat
);
    import frp_pkg::*;

    logic [DIV_NUM_W-1:0] num_hi;
    logic [DIV_Q_W-1:0]   num_lo;
    logic                 sat_now;
    logic [DIV_DEN_W:0]   trial;
    logic                 trial_ge;
    logic [DIV_DEN_W-1:0] rem_next;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_lo;
    logic [DIV_DEN_W-1:0] r_den;
    logic                 r_sat;
    logic [DIV_CNT_W-1:0] r_steps;

    // upper part seeds the remainder, lower steps bits are shifted in
    assign num_hi  = i_num >> i_req.steps;
    assign num_lo  = DIV_Q_W'(i_num << (DIV_CNT_W'(DIV_Q_W) - i_req.steps));
    assign sat_now = num_hi >= DIV_NUM_W'(i_den);

    assign trial    = {r_rem, r_lo[DIV_Q_W-1]};
    assign trial_ge = trial >= {1'b0, r_den};
    assign rem_next = trial_ge ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.go) begin
                r_done <= sat_now;
                if (!sat_now) begin
                    r_busy <= 1'b1;
                    r_cnt  <= i_req.steps;
                end
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == DIV_CNT_W'(1));
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem   <= num_hi[DIV_DEN_W-1:0];
            r_lo    <= num_lo;
            r_den   <= i_den;
            r_sat   <= sat_now;
            r_steps <= i_req.steps;
        end else if (r_busy) begin
            r_rem <= rem_next;
            r_lo  <= {r_lo[DIV_Q_W-2:0], trial_ge};
        end
    end

    always_comb begin
        o_stat.done = r_done;
        o_stat.quot = r_sat ? ~({DIV_Q_W{1'b1}} << r_steps) : r_lo;
    end

    `FMPR_ASSERT_NEVER(a_go_while_busy, i_clk, i_rst_n, i_req.go && r_busy, "divider restarted mid-run")
    `FMPR_ASSERT_IMPLY(a_cnt_live, i_clk, i_rst_n, r_busy, r_cnt != '0, "divider busy with no steps left")
    `FMPR_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "divider done held two cycles")

endmodule

`default_nettype wire

// ===== design/flow_meter_pulse_rate_unit.sv =====
// Flow meter pulse-rate unit: pulse and clear words are accepted back to back.
// A tick finishes sooner when a quotient saturates and later while an earlier result word
// still waits at the output; no input word is taken until a tick's result is registered.
// Five divisions run on one restoring divider at one quotient bit per cycle, with
// quotients of 32, 4, 16, 32 and 32 bits.
// Reset (i_rst_n low, synchronous): count and totals zero, registers to defaults.
`default_nettype none
`include "flow_meter_pulse_rate_unit_macros.svh"

module flow_meter_pulse_rate_unit #(
    parameter int unsigned PULSE_COUNT_WIDTH = frp_pkg::PULSE_COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    // input words
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [frp_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [frp_pkg::DUR_W-1:0]       i_duration_ms,

    // result words
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [frp_pkg::VAL_W-1:0]            o_frequency,
    output logic [frp_pkg::VAL_W-1:0]            o_rate,
    output logic [frp_pkg::VAL_W-1:0]            o_quantity,
    output logic [frp_pkg::K_W-1:0]              o_correction,
    output logic [frp_pkg::DEC_W-1:0]            o_decile,
    output logic [frp_pkg::SUM_W-1:0]            o_sum_quantity,
    output logic [frp_pkg::SUM_W-1:0]            o_sum_duration,
    output logic [frp_pkg::SUMC_W-1:0]           o_sum_correction,
    output logic                                 o_zero_window,

    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [frp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [frp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import frp_pkg::*;

    // Sequencer: S_IDLE sets up the frequency division, every later one gets a SET state (operands
    // into the divider input registers, go pulse); each has a WAIT state (catch the quotient).
    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT_F,
        S_SET_DEC,
        S_WAIT_DEC,
        S_SET_C,
        S_WAIT_C,
        S_SET_R,
        S_WAIT_R,
        S_SET_Q,
        S_WAIT_Q,
        S_UPD
    } t_state;

    t_state r_state;

    // configuration registers
    logic [CAP_W-1:0]      r_capacity;
    logic [K_W-1:0]        r_k;
    logic [CFG_DATA_W-1:0] r_m_low;
    logic [CFG_DATA_W-1:0] r_m_mid;
    logic [MHIGH_W-1:0]    r_m_high;

    // state
    logic [PULSE_COUNT_WIDTH-1:0] r_count;
    logic [SUM_W-1:0]             r_tot_q;
    logic [SUM_W-1:0]             r_tot_d;
    logic [SUMC_W-1:0]            r_tot_c;

    // divider operands
    logic                 r_go;
    logic [DIV_CNT_W-1:0] r_steps;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    t_div_req             div_req;
    t_div_stat            div_stat;

    // per-tick working values
    logic [DUR_W-1:0] r_d;
    logic             r_zw;
    logic [VAL_W-1:0] r_f;
    logic [DEC_W-1:0] r_dec;
    logic [K_W-1:0]   r_c;
    logic [VAL_W-1:0] r_r;
    logic [VAL_W-1:0] r_q;
    logic [CD_W-1:0]  r_cd;

    // result register; frees the working set for the next tick
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_f;
    logic [VAL_W-1:0] r_out_r;
    logic [VAL_W-1:0] r_out_q;
    logic [K_W-1:0]   r_out_c;
    logic [DEC_W-1:0] r_out_dec;
    logic             r_out_zw;

    logic             in_accept;
    logic [M_W-1:0]   m_sel;
    logic [CK_W-1:0]  cap_k;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // m-factor lane for the current decile; deciles 8 and 9 sit in the high word
    always_comb begin
        if (r_dec < DEC_W'(4)) begin
            m_sel = r_m_low[16*r_dec[1:0] +: M_W];
        end else if (r_dec < DEC_W'(8)) begin
            m_sel = r_m_mid[16*r_dec[1:0] +: M_W];
        end else begin
            m_sel = r_m_high[16*r_dec[0] +: M_W];
        end
    end

    assign cap_k = CK_W'(r_capacity) * CK_W'(r_k);

    assign div_req.go    = r_go;
    assign div_req.steps = r_steps;

    frp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_stat  (div_stat)
    );

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
            r_k        <= K_FACTOR_RST;
            r_m_low    <= M_LOW_RST;
            r_m_mid    <= M_MID_RST;
            r_m_high   <= M_HIGH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                CFG_K_FACTOR: r_k        <= i_cfg_data[K_W-1:0];
                CFG_M_LOW:    r_m_low    <= i_cfg_data;
                CFG_M_MID:    r_m_mid    <= i_cfg_data;
                CFG_M_HIGH:   r_m_high   <= i_cfg_data[MHIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_tot_q     <= '0;
            r_tot_d     <= '0;
            r_tot_c     <= '0;
        end else begin
            // S_UPD reloads the result register itself
            if (r_out_valid && i_out_ready && (r_state != S_UPD)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_go <= in_accept && (i_kind == KIND_TICK);
                    if (in_accept) begin
                        unique case (i_kind)
                            KIND_PULSE: begin
                                if (r_count != '1) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            KIND_CLEAR: begin
                                r_count <= '0;
                            end
                            KIND_TICK: begin
                                // frequency = count * 1000 * 2^16 / d
                                r_num   <= DIV_NUM_W'(r_count) * FREQ_SCALE;
                                r_den   <= DIV_DEN_W'(i_duration_ms);
                                r_steps <= STEPS_VAL;
                                r_d     <= i_duration_ms;
                                r_zw    <= (i_duration_ms == '0);
                                r_count <= '0;
                                r_state <= S_WAIT_F;
                            end
                            default: ;  // unused kind: dropped
                        endcase
                    end
                end

                S_WAIT_F: begin
                    r_go <= 1'b0;
                    if (div_stat.done) begin
                        r_f     <= r_zw ? '0 : div_stat.quot;
                        r_state <= S_SET_DEC;
                    end
                end

                S_SET_DEC: begin
                    // decile = 10*F / (256*capacity*k); zero divisor saturates to 9
                    r_num   <= DIV_NUM_W'(r_f) * DECILE_SCALE;
                    r_den   <= DIV_DEN_W'({cap_k, 8'b0});
                    r_steps <= STEPS_DEC;
                    r_go    <= 1'b1;
                    r_state <= S_WAIT_DEC;
                end

                S_WAIT_DEC: begin
                    r_go <= 1'b0;
                    if (div_stat.done) begin
                        r_dec   <= (div_stat.quot[DEC_W-1:0] > DEC_MAX) ?
                                   DEC_MAX : div_stat.quot[DEC_W-1:0];
                        r_state <= S_SET_C;
                    end
                end

                S_SET_C: begin
                    // correction = k * 2^14 / m, zero m saturates
                    r_num   <= DIV_NUM_W'({r_k, 14'b0});
                    r_den   <= DIV_DEN_W'(m_sel);
                    r_steps <= STEPS_CORR;
                    r_go    <= 1'b1;
                    r_state <= S_WAIT_C;
                end

                S_WAIT_C: begin
                    r_go <= 1'b0;
                    if (div_stat.done) begin
                        r_c     <= div_stat.quot[K_W-1:0];
                        r_state <= S_SET_R;
                    end
                end

                S_SET_R: begin
                    // rate = F * 256 / correction
                    r_num   <= DIV_NUM_W'({r_f, 8'b0});
                    r_den   <= DIV_DEN_W'(r_c);
                    r_steps <= STEPS_VAL;
                    r_go    <= 1'b1;
                    r_state <= S_WAIT_R;
                end

                S_WAIT_R: begin
                    r_go <= 1'b0;
                    if (div_stat.done) begin
                        // zero frequency gives zero rate, even with zero correction
                        r_r     <= (r_f == '0) ? '0 : div_stat.quot;
                        r_state <= S_SET_Q;
                    end
                end

                S_SET_Q: begin
                    // quantity = rate * d / 60000
                    r_num   <= DIV_NUM_W'(r_r) * DIV_NUM_W'(r_d);
                    r_den   <= MS_PER_MIN;
                    r_steps <= STEPS_VAL;
                    r_go    <= 1'b1;
                    r_cd    <= CD_W'(r_c) * CD_W'(r_d);
                    r_state <= S_WAIT_Q;
                end

                S_WAIT_Q: begin
                    r_go <= 1'b0;
                    if (div_stat.done) begin
                        r_q     <= div_stat.quot;
                        r_state <= S_UPD;
                    end
                end

                S_UPD: begin
                    r_go <= 1'b0;
                    // totals move only with a result, so they double as the sum outputs
                    if (!r_out_valid || i_out_ready) begin
                        r_tot_q     <= r_tot_q + SUM_W'(r_q);
                        r_tot_d     <= r_tot_d + SUM_W'(r_d);
                        r_tot_c     <= r_tot_c + SUMC_W'(r_cd);
                        r_out_f     <= r_f;
                        r_out_r     <= r_r;
                        r_out_q     <= r_q;
                        r_out_c     <= r_c;
                        r_out_dec   <= r_dec;
                        r_out_zw    <= r_zw;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_go    <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frequency      = r_out_f;
    assign o_rate           = r_out_r;
    assign o_quantity       = r_out_q;
    assign o_correction     = r_out_c;
    assign o_decile         = r_out_dec;
    assign o_zero_window    = r_out_zw;
    assign o_sum_quantity   = r_tot_q;
    assign o_sum_duration   = r_tot_d;
    assign o_sum_correction = r_tot_c;

    `FMPR_ASSERT_NEXT(a_tick_starts, i_clk, i_rst_n, in_accept && (i_kind == KIND_TICK), r_go && (r_state == S_WAIT_F), "tick did not start the divider")
    `FMPR_ASSERT_NEXT(a_count_sat, i_clk, i_rst_n, in_accept && (i_kind == KIND_PULSE) && (r_count == '1), r_count == '1, "pulse count wrapped")
    `FMPR_ASSERT_NEXT(a_upd_holds, i_clk, i_rst_n, (r_state == S_UPD) && r_out_valid && !i_out_ready, r_state == S_UPD, "result overwritten before taken")
    `FMPR_ASSERT_IMPLY(a_decile_range, i_clk, i_rst_n, r_out_valid, r_out_dec <= DEC_MAX, "decile above 9")

endmodule

`default_nettype wire
